>>> rtl/msc_pkg.sv
package msc_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW         = $clog2(DEPTH);
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int HW         = $clog2(MAX_HEIGHT + 1);
	localparam int COLW       = $clog2(MAX_WIDTH);
	localparam int COST_W     = 34;
	localparam int CFG_W      = 10;

	localparam logic [1:0] CLASS_PLAIN = 2'd0;
	localparam logic [1:0] CLASS_RED   = 2'd1;
	localparam logic [1:0] CLASS_GREEN = 2'd2;

	localparam logic [1:0] FROM_MID   = 2'd0;
	localparam logic [1:0] FROM_RIGHT = 2'd1;
	localparam logic [1:0] FROM_LEFT  = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SEAMS  = 2'd2;

	localparam logic [23:0] SEAM_PIXEL = 24'hFF0000;

	// squared distance of two RGB pixels, max 3*255^2
	function automatic logic [17:0] grad_sq(input logic [23:0] a, input logic [23:0] b);
		logic signed [8:0]  d0, d1, d2;
		logic        [17:0] s;
		d0 = $signed({1'b0, a[23:16]}) - $signed({1'b0, b[23:16]});
		d1 = $signed({1'b0, a[15:8]}) - $signed({1'b0, b[15:8]});
		d2 = $signed({1'b0, a[7:0]}) - $signed({1'b0, b[7:0]});
		s = 18'(unsigned'(17'(d0 * d0))) + 18'(unsigned'(17'(d1 * d1)))
			+ 18'(unsigned'(17'(d2 * d2)));
		return s;
	endfunction

endpackage

>>> rtl/masked_seam_carver.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | kind, pixel_*, mask_*
// out     | output    | out_valid / out_stall | out_red/green/blue, frame_end
// cfg     | input     | cfg_write             | cfg_index, cfg_data
// A load is written when accepted; a read goes through one memory read, then the output register.
// The load that completes the frame starts carving: per seam an energy and cost sweep
// (five pixel reads per pixel on the single read port), then the minimum search and a
// backtrack that shifts the pixels of each row.
// Input stalls during carving, while a read is in flight, and while a result is stalled.
// Reset clears control state only; the image and cost memories are undefined until written.
module masked_seam_carver import msc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	input  logic [7:0]       pixel_red,
	input  logic [7:0]       pixel_green,
	input  logic [7:0]       pixel_blue,
	input  logic [7:0]       mask_red,
	input  logic [7:0]       mask_green,
	input  logic [7:0]       mask_blue,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic             frame_end
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b00000001,
		ST_START  = 8'b00000010,
		ST_PIX    = 8'b00000100,
		ST_MIN    = 8'b00001000,
		ST_BT_RD  = 8'b00010000,
		ST_BT_CAP = 8'b00100000,
		ST_SHIFT  = 8'b01000000,
		ST_BT_END = 8'b10000000
	} state_t;

	state_t state_q;

	logic [9:0] width_cfg_q, height_cfg_q;
	logic [8:0] seams_cfg_q;

	// pixel store: {class, rgb}
	logic [25:0] pix_mem [DEPTH];
	logic [25:0] pix_rd_q;
	logic [AW-1:0] pix_raddr, pix_waddr;
	logic [25:0] pix_wdata;
	logic pix_we;

	logic [1:0] came_mem [DEPTH];
	logic [1:0] came_rd_q;
	logic came_we;
	logic [AW-1:0] came_raddr;

	logic signed [COST_W-1:0] cost_mem [2*MAX_WIDTH];
	logic signed [COST_W-1:0] cost_rd_q;
	logic [COLW:0] cost_raddr, cost_waddr;
	logic signed [COST_W-1:0] cost_wdata;
	logic cost_we;

	logic [WW-1:0] eff_w, w_q, cw_q, n_q, done_q, col_q, best_col_q, mcol_q, mc_s1, j_q;
	logic [HW-1:0] eff_h, h_q, row_q;
	logic [AW:0]   total, lpos_q, rpos_q, lpos_eff, rpos_eff;
	logic [AW-1:0] idx_q, rowbase_q, base_q, sa_s1;
	logic [3:0]    ph_q;
	logic          rd_pend_q, fe_pend_q, mv_s1, sv_s1, int_q;
	logic [1:0]    cls_q, save_cls_q, code_q, mcls;
	logic [23:0]   ea_q, we_q, no_q, so_q;
	logic signed [COST_W-1:0] cl_q, cm_q, cr_q, e_hold_q, sl_q, sm_q, sr_q, best_q, energy;

	logic in_acc, dp, interior;
	logic [WW:0] colx, cwx;

	always_comb begin
		if (width_cfg_q < 10'd5) eff_w = WW'(5);
		else if (int'(width_cfg_q) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
		else eff_w = WW'(width_cfg_q);
		if (height_cfg_q < 10'd3) eff_h = HW'(3);
		else if (int'(height_cfg_q) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
		else eff_h = HW'(height_cfg_q);
		total = (AW+1)'(eff_w) * (AW+1)'(eff_h);
		lpos_eff = (lpos_q >= total) ? '0 : lpos_q;
		rpos_eff = (rpos_q >= total) ? '0 : rpos_q;
		mcls = CLASS_PLAIN;
		if (mask_red > mask_green && mask_blue < 8'd100) mcls = CLASS_RED;
		else if (mask_green > mask_red && mask_blue < 8'd100) mcls = CLASS_GREEN;
	end

	assign in_stall = (state_q != ST_IDLE) || rd_pend_q || (out_valid && out_stall);
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		colx = {1'b0, col_q};
		cwx  = {1'b0, cw_q};
		dp = (row_q != '0) && (colx >= (WW+1)'(2)) && (colx + (WW+1)'(3) <= cwx);
		interior = (row_q != '0) && ((HW+1)'(row_q) + (HW+1)'(2) <= (HW+1)'(h_q))
			&& (col_q != '0) && (colx + (WW+1)'(2) <= cwx);
	end

	// read port selection
	always_comb begin
		pix_raddr  = idx_q;
		cost_raddr = {~row_q[0], col_q[COLW-1:0] - COLW'(1)};
		unique case (state_q)
			ST_IDLE: pix_raddr = rpos_eff[AW-1:0];
			ST_PIX: begin
				case (ph_q)
					4'd1: begin
						pix_raddr  = interior ? idx_q + AW'(1) : idx_q;
						cost_raddr = {~row_q[0], col_q[COLW-1:0]};
					end
					4'd2: begin
						pix_raddr  = interior ? idx_q - AW'(1) : idx_q;
						cost_raddr = {~row_q[0], col_q[COLW-1:0] + COLW'(1)};
					end
					4'd3: pix_raddr = interior ? idx_q - AW'(w_q) : idx_q;
					4'd4: pix_raddr = interior ? idx_q + AW'(w_q) : idx_q;
					default: pix_raddr = idx_q;
				endcase
			end
			ST_MIN: cost_raddr = {h_q[0] ^ 1'b1, mcol_q[COLW-1:0]};
			ST_BT_RD: pix_raddr = base_q + AW'(col_q);
			ST_SHIFT: pix_raddr = base_q + AW'(j_q);
			default: pix_raddr = idx_q;
		endcase
		came_raddr = base_q + AW'(col_q);
	end

	// write ports
	always_comb begin
		pix_we    = 1'b0;
		pix_waddr = lpos_eff[AW-1:0];
		pix_wdata = {mcls, pixel_red, pixel_green, pixel_blue};
		if (state_q == ST_IDLE) begin
			pix_we = in_acc && !kind;
		end else if (state_q == ST_SHIFT) begin
			pix_we    = sv_s1;
			pix_waddr = sa_s1;
			pix_wdata = pix_rd_q;
		end else if (state_q == ST_BT_END) begin
			pix_we    = 1'b1;
			pix_waddr = base_q + AW'(cw_q) - AW'(1);
			pix_wdata = {save_cls_q, SEAM_PIXEL};
		end
		cost_we    = (state_q == ST_PIX) && (ph_q == 4'd8);
		cost_waddr = {row_q[0], col_q[COLW-1:0]};
		came_we    = cost_we && dp;
		cost_wdata = e_hold_q;
	end

	logic [1:0] sel_code;
	always_comb begin
		if (sm_q <= sl_q && sm_q <= sr_q) begin
			sel_code = FROM_MID;
		end else if (sr_q <= sl_q) begin
			sel_code = FROM_RIGHT;
		end else begin
			sel_code = FROM_LEFT;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
		pix_rd_q <= pix_mem[pix_raddr];
		if (came_we) came_mem[idx_q] <= sel_code;
		came_rd_q <= came_mem[came_raddr];
		if (cost_we) begin
			if (!dp) cost_mem[cost_waddr] <= cost_wdata;
			else if (sel_code == FROM_MID) cost_mem[cost_waddr] <= sm_q;
			else if (sel_code == FROM_RIGHT) cost_mem[cost_waddr] <= sr_q;
			else cost_mem[cost_waddr] <= sl_q;
		end
		cost_rd_q <= cost_mem[cost_raddr];
	end

	msc_energy u_energy (
		.clk      (clk),
		.cls      (cls_q),
		.interior (int_q),
		.east     (ea_q),
		.west     (we_q),
		.north    (no_q),
		.south    (so_q),
		.energy_s1(energy)
	);

	// datapath registers of the per-pixel sweep, minimum search, backtrack and read output
	always_ff @(posedge clk) begin
		if (state_q == ST_PIX) begin
			case (ph_q)
				4'd0: int_q <= interior;
				4'd1: begin cls_q <= pix_rd_q[25:24]; cl_q <= cost_rd_q; end
				4'd2: begin ea_q <= pix_rd_q[23:0]; cm_q <= cost_rd_q; end
				4'd3: begin we_q <= pix_rd_q[23:0]; cr_q <= cost_rd_q; end
				4'd4: no_q <= pix_rd_q[23:0];
				4'd5: so_q <= pix_rd_q[23:0];
				4'd7: begin
					e_hold_q <= energy;
					sl_q <= energy + cl_q;
					sm_q <= energy + cm_q;
					sr_q <= energy + cr_q;
				end
				default: ;
			endcase
		end
		if (state_q == ST_MIN && mv_s1 && (mc_s1 == WW'(2) || cost_rd_q < best_q)) begin
			best_q     <= cost_rd_q;
			best_col_q <= mc_s1;
		end
		if (state_q == ST_BT_CAP) begin
			save_cls_q <= pix_rd_q[25:24];
			code_q     <= came_rd_q;
		end
		if (rd_pend_q) begin
			out_red   <= pix_rd_q[23:16];
			out_green <= pix_rd_q[15:8];
			out_blue  <= pix_rd_q[7:0];
			frame_end <= fe_pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			width_cfg_q  <= 10'd512;
			height_cfg_q <= 10'd512;
			seams_cfg_q  <= 9'd50;
			lpos_q       <= '0;
			rpos_q       <= '0;
			rd_pend_q    <= 1'b0;
			fe_pend_q    <= 1'b0;
			out_valid    <= 1'b0;
			w_q          <= '0;
			h_q          <= '0;
			cw_q         <= '0;
			n_q          <= '0;
			done_q       <= '0;
			col_q        <= '0;
			row_q        <= '0;
			idx_q        <= '0;
			rowbase_q    <= '0;
			base_q       <= '0;
			ph_q         <= '0;
			mcol_q       <= '0;
			mc_s1        <= '0;
			mv_s1        <= 1'b0;
			sv_s1        <= 1'b0;
			sa_s1        <= '0;
			j_q          <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_WIDTH:  width_cfg_q  <= cfg_data;
					REG_HEIGHT: height_cfg_q <= cfg_data;
					REG_SEAMS:  seams_cfg_q  <= cfg_data[8:0];
					default: ;
				endcase
			end
			rd_pend_q <= (state_q == ST_IDLE) && in_acc && kind;
			if (rd_pend_q) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && kind) begin
						fe_pend_q <= (rpos_eff + 1'b1 == total);
						rpos_q    <= (rpos_eff + 1'b1 >= total) ? '0 : rpos_eff + 1'b1;
					end else if (in_acc) begin
						if (lpos_eff + 1'b1 == total) begin
							lpos_q  <= '0;
							rpos_q  <= '0;
							w_q     <= eff_w;
							h_q     <= eff_h;
							cw_q    <= eff_w;
							done_q  <= '0;
							n_q     <= (int'(seams_cfg_q) < int'(eff_w) - 5) ?
								WW'(seams_cfg_q) : eff_w - WW'(5);
							state_q <= ST_START;
						end else begin
							lpos_q <= lpos_eff + 1'b1;
						end
					end
				end
				ST_START: begin
					// begin a pass, or finish when all seams are gone
					col_q     <= '0;
					row_q     <= '0;
					idx_q     <= '0;
					rowbase_q <= '0;
					ph_q      <= '0;
					state_q   <= (done_q < n_q) ? ST_PIX : ST_IDLE;
				end
				ST_PIX: begin
					if (ph_q == 4'd8) begin
						ph_q <= '0;
						if (col_q == cw_q - WW'(1)) begin
							col_q <= '0;
							if ({1'b0, row_q} == (HW+1)'(h_q) - (HW+1)'(1)) begin
								mcol_q  <= WW'(2);
								mv_s1   <= 1'b0;
								state_q <= ST_MIN;
							end else begin
								row_q     <= row_q + HW'(1);
								rowbase_q <= rowbase_q + AW'(w_q);
								idx_q     <= rowbase_q + AW'(w_q);
							end
						end else begin
							col_q <= col_q + WW'(1);
							idx_q <= idx_q + AW'(1);
						end
					end else begin
						ph_q <= ph_q + 4'd1;
					end
				end
				ST_MIN: begin
					if ({1'b0, mcol_q} + (WW+1)'(3) <= {1'b0, cw_q}) begin
						mv_s1  <= 1'b1;
						mc_s1  <= mcol_q;
						mcol_q <= mcol_q + WW'(1);
					end else begin
						mv_s1 <= 1'b0;
						if (!mv_s1) begin
							// drained: start backtrack at the last row
							col_q   <= best_col_q;
							row_q   <= h_q - HW'(1);
							base_q  <= AW'(h_q - HW'(1)) * AW'(w_q);
							state_q <= ST_BT_RD;
						end
					end
				end
				ST_BT_RD: state_q <= ST_BT_CAP;
				ST_BT_CAP: begin
					j_q     <= col_q + WW'(1);
					sv_s1   <= 1'b0;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (j_q < cw_q) begin
						sv_s1 <= 1'b1;
						sa_s1 <= base_q + AW'(j_q) - AW'(1);
						j_q   <= j_q + WW'(1);
					end else begin
						sv_s1 <= 1'b0;
						if (!sv_s1) state_q <= ST_BT_END;
					end
				end
				ST_BT_END: begin
					if (row_q != '0 && {1'b0, col_q} >= (WW+1)'(2)
						&& {1'b0, col_q} + (WW+1)'(3) <= {1'b0, cw_q}) begin
						if (code_q == FROM_RIGHT) col_q <= col_q + WW'(1);
						else if (code_q == FROM_LEFT) col_q <= col_q - WW'(1);
					end
					if (row_q == '0) begin
						// pass done: narrow and go again
						cw_q    <= cw_q - WW'(1);
						done_q  <= done_q + WW'(1);
						state_q <= ST_START;
					end else begin
						row_q   <= row_q - HW'(1);
						base_q  <= base_q - AW'(w_q);
						state_q <= ST_BT_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/msc_energy.sv
module msc_energy import msc_pkg::*; (
	input  logic                     clk,
	input  logic [1:0]               cls,
	input  logic                     interior,
	input  logic [23:0]              east,
	input  logic [23:0]              west,
	input  logic [23:0]              north,
	input  logic [23:0]              south,
	output logic signed [COST_W-1:0] energy_s1
);

	logic [18:0]              grad;
	logic signed [COST_W-1:0] e;

	always_comb begin
		grad = 19'(grad_sq(east, west)) + 19'(grad_sq(north, south));
		if (cls == CLASS_RED) begin
			e = -COST_W'(999999);
		end else if (cls == CLASS_GREEN) begin
			e = COST_W'(999999);
		end else if (interior) begin
			e = $signed(COST_W'(grad)) - COST_W'(100000);
		end else begin
			e = -COST_W'(100000);
		end
	end

	always_ff @(posedge clk) begin
		energy_s1 <= e;
	end

endmodule

>>> bench/tb_masked_seam_carver.sv
module tb_masked_seam_carver import msc_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} carved_pixel_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_write;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic             kind;
	logic [7:0]       pixel_red, pixel_green, pixel_blue;
	logic [7:0]       mask_red, mask_green, mask_blue;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       out_red, out_green, out_blue;
	logic             frame_end;

	masked_seam_carver i_dut (.*);

	// model state of the carver
	logic [23:0] img_mem [DEPTH];
	logic [1:0]  class_mem [DEPTH];
	logic [1:0]  from_mem [DEPTH];
	bit          written_map [DEPTH];
	longint      path_cost [2][MAX_WIDTH];
	int          reg_width, reg_height, reg_seams;
	int          load_pos, read_pos;

	carved_pixel_t expected_pixels [$];
	int     errors, mismatches;
	longint cycles;
	int     loads_sent, reads_sent, frames_carved, seams_carved, pixels_checked;
	bit     quiet;
	int     hold_left;

	initial begin
		clk = 0;
		forever begin
			#4 clk = 1;
			#4 clk = 0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels pending", cycles,
				expected_pixels.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int frame_w();
		return reg_width < 5 ? 5 : (reg_width > MAX_WIDTH ? MAX_WIDTH : reg_width);
	endfunction

	function automatic int frame_h();
		return reg_height < 3 ? 3 : (reg_height > MAX_HEIGHT ? MAX_HEIGHT : reg_height);
	endfunction

	function automatic int dist_sq(logic [23:0] a, logic [23:0] b);
		int dr, dg, db;
		dr = int'(a[23:16]) - int'(b[23:16]);
		dg = int'(a[15:8]) - int'(b[15:8]);
		db = int'(a[7:0]) - int'(b[7:0]);
		return dr * dr + dg * dg + db * db;
	endfunction

	function automatic longint pixel_energy(int h, int w, int cw, int sw, int sh);
		int idx, e;
		idx = h * sw + w;
		e = 0;
		if (class_mem[idx] == CLASS_RED) return -999999;
		if (class_mem[idx] == CLASS_GREEN) return 999999;
		if (h >= 1 && h <= sh - 2 && w >= 1 && w <= cw - 2)
			e = dist_sq(img_mem[idx + 1], img_mem[idx - 1])
				+ dist_sq(img_mem[idx - sw], img_mem[idx + sw]);
		return longint'(e) - 100000;
	endfunction

	task automatic remove_one_seam(int sw, int sh, int cw);
		int h, w, k, col, base, pr, cr;
		longint e, lc, mc, rc, best_cost;
		logic [1:0] cls;
		for (w = 0; w < cw; w++)
			path_cost[0][w] = pixel_energy(0, w, cw, sw, sh);
		for (h = 1; h < sh; h++) begin
			pr = (h - 1) & 1;
			cr = h & 1;
			for (w = 0; w < cw; w++) begin
				e = pixel_energy(h, w, cw, sw, sh);
				if (w >= 2 && w + 3 <= cw) begin
					lc = e + path_cost[pr][w - 1];
					mc = e + path_cost[pr][w];
					rc = e + path_cost[pr][w + 1];
					// ties: middle, then right, then left
					if (mc <= lc && mc <= rc) begin
						e = mc;
						from_mem[h * sw + w] = FROM_MID;
					end else if (rc <= lc) begin
						e = rc;
						from_mem[h * sw + w] = FROM_RIGHT;
					end else begin
						e = lc;
						from_mem[h * sw + w] = FROM_LEFT;
					end
				end
				path_cost[cr][w] = e;
			end
		end
		col = 2;
		best_cost = path_cost[(sh - 1) & 1][2];
		for (w = 2; w + 3 <= cw; w++)
			if (path_cost[(sh - 1) & 1][w] < best_cost) begin
				best_cost = path_cost[(sh - 1) & 1][w];
				col = w;
			end
		for (h = sh - 1; h >= 0; h--) begin
			base = h * sw;
			cls = class_mem[base + col];
			for (k = col; k < cw - 1; k++) begin
				img_mem[base + k] = img_mem[base + k + 1];
				class_mem[base + k] = class_mem[base + k + 1];
			end
			img_mem[base + cw - 1] = SEAM_PIXEL;
			class_mem[base + cw - 1] = cls;
			if (h >= 1 && col >= 2 && col + 3 <= cw) begin
				if (from_mem[base + col] == FROM_RIGHT) col++;
				else if (from_mem[base + col] == FROM_LEFT) col--;
			end
		end
	endtask

	task automatic predict_request(logic k, logic [7:0] pr, pg, pb, mr, mg, mb);
		int total, n, cw;
		logic [1:0] cls;
		carved_pixel_t px;
		total = frame_w() * frame_h();
		if (!k) begin
			loads_sent++;
			if (load_pos >= total) load_pos = 0;
			cls = CLASS_PLAIN;
			if (mr > mg && mb < 100) cls = CLASS_RED;
			else if (mg > mr && mb < 100) cls = CLASS_GREEN;
			img_mem[load_pos] = {pr, pg, pb};
			class_mem[load_pos] = cls;
			written_map[load_pos] = 1;
			load_pos++;
			if (load_pos == total) begin
				n = reg_seams < frame_w() - 5 ? reg_seams : frame_w() - 5;
				for (cw = frame_w(); cw > frame_w() - n; cw--)
					remove_one_seam(frame_w(), frame_h(), cw);
				frames_carved++;
				seams_carved += n;
				load_pos = 0;
				read_pos = 0;
			end
		end else begin
			reads_sent++;
			if (read_pos >= total) read_pos = 0;
			px.red = img_mem[read_pos][23:16];
			px.green = img_mem[read_pos][15:8];
			px.blue = img_mem[read_pos][7:0];
			px.last = (read_pos + 1 == total);
			expected_pixels.push_back(px);
			read_pos++;
			if (read_pos >= total) read_pos = 0;
		end
	endtask

	function automatic bit read_is_safe();
		int total;
		total = frame_w() * frame_h();
		return written_map[read_pos >= total ? 0 : read_pos];
	endfunction

	// offer one request, wait for acceptance, leave valid high
	task automatic send_request(logic k, logic [7:0] pr, pg, pb, mr, mg, mb);
		while (!quiet && $urandom_range(99) < 33) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		pixel_red <= pr;
		pixel_green <= pg;
		pixel_blue <= pb;
		mask_red <= mr;
		mask_green <= mg;
		mask_blue <= mb;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_request(k, pr, pg, pb, mr, mg, mb);
	endtask

	task automatic send_random_load();
		logic [7:0] mr, mg, mb;
		mr = 8'($urandom);
		mg = 8'($urandom);
		mb = 8'($urandom);
		case ($urandom_range(3))
			0: begin
				mr = 8'($urandom_range(255, 1));
				mg = 8'($urandom_range(mr - 1));
				mb = 8'($urandom_range(99));
			end
			1: begin
				mg = 8'($urandom_range(255, 1));
				mr = 8'($urandom_range(mg - 1));
				mb = 8'($urandom_range(99));
			end
			default: ;
		endcase
		send_request(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), mr, mg, mb);
	endtask

	task automatic send_read();
		send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
	endtask

	// drop valid and wait until results are drained and carving has finished
	task automatic wait_idle();
		int calm;
		in_valid <= 0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		calm = 0;
		while (calm < 8) begin
			@(posedge clk);
			calm = in_stall ? 0 : calm + 1;
		end
	endtask

	task automatic write_registers(int w, int h, int s);
		int vals [3];
		vals = '{w, h, s};
		foreach (vals[i]) begin
			cfg_write <= 1;
			cfg_index <= (i == 0) ? REG_WIDTH : (i == 1) ? REG_HEIGHT : REG_SEAMS;
			cfg_data <= CFG_W'(vals[i]);
			@(posedge clk);
		end
		cfg_write <= 0;
		reg_width = w & 10'h3FF;
		reg_height = h & 10'h3FF;
		reg_seams = s & 9'h1FF;
	endtask

	task automatic carve_random_frame(int w, int h, int s, int extra_reads);
		int i;
		wait_idle();
		write_registers(w, h, s);
		for (i = 0; i < frame_w() * frame_h(); i++) begin
			if ($urandom_range(9) == 0 && read_is_safe()) send_read();
			send_random_load();
		end
		for (i = 0; i < frame_w() * frame_h() + extra_reads; i++) begin
			if ($urandom_range(19) == 0) send_random_load();
			else if (read_is_safe()) send_read();
		end
	endtask

	// undersized registers clamp; seam count clamps to zero at width 5
	task automatic test_directed();
		logic [7:0] v;
		int i;
		write_registers(0, 0, 9'h1FF);
		send_request(0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
		send_request(0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h63);
		send_request(0, 8'h80, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h64);
		send_request(0, 8'h7F, 8'hFE, 8'h01, 8'h55, 8'h55, 8'h00);
		send_request(0, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF);
		for (i = 0; i < 10; i++) begin
			v = (i & 1) ? 8'hFF : 8'h00;
			send_request(0, v, ~v, 8'hA5, v, ~v, 8'h5A);
		end
		// read back the first ten pixels of the carved frame
		for (i = 0; i < 10; i++) send_read();
	endtask

	// a config change leaves the load position past the new frame end
	task automatic test_position_wrap();
		int i;
		wait_idle();
		write_registers(8, 6, 2);
		for (i = 0; i < 20; i++) send_random_load();
		wait_idle();
		write_registers(5, 3, 0);
		for (i = 0; i < 6; i++) send_read();
		for (i = 0; i < 15; i++) send_random_load();
		for (i = 0; i < 16; i++) send_read();
	endtask

	task automatic test_carving();
		int p;
		carve_random_frame(5, 3, 0, 3);
		carve_random_frame(6, 3, 1, 2);
		carve_random_frame(9, 4, 9'h1FF, 4);
		for (p = 0; p < 8; p++)
			carve_random_frame($urandom_range(12, 5), $urandom_range(8, 3),
				$urandom_range(8), $urandom_range(5));
	endtask

	task automatic test_wide_frame();
		carve_random_frame(32, 3, 3, 2);
	endtask

	task automatic test_back_pressure();
		int i;
		carve_random_frame(7, 5, 2, 0);
		quiet = 1;
		hold_left = 400;
		for (i = 0; i < 40; i++) send_read();
		// hold until every result is back, then go on
		in_valid <= 0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		for (i = 0; i < 30; i++) send_read();
		quiet = 0;
	endtask

	always @(posedge clk) begin
		carved_pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			pixels_checked++;
			if (expected_pixels.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected pixel %h %h %h last=%b", out_red, out_green,
						out_blue, frame_end);
			end else begin
				want = expected_pixels.pop_front();
				if (want != {out_red, out_green, out_blue, frame_end}) begin
					errors++;
					if (mismatches++ < 10)
						$display("pixel mismatch: want %h %h %h last=%b, got %h %h %h last=%b",
							want.red, want.green, want.blue, want.last,
							out_red, out_green, out_blue, frame_end);
				end
			end
		end
	end

	// receiver stall: a counted hold, otherwise random idling
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else
			out_stall <= !quiet && $urandom_range(99) < 33;
	end

	initial begin
		arst_n = 0;
		cfg_write = 0;
		cfg_index = REG_WIDTH;
		cfg_data = 0;
		in_valid = 0;
		kind = 0;
		{pixel_red, pixel_green, pixel_blue} = 0;
		{mask_red, mask_green, mask_blue} = 0;
		out_stall = 0;
		reg_width = 512;
		reg_height = 512;
		reg_seams = 50;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_position_wrap();
		test_carving();
		test_wide_frame();
		test_back_pressure();
		in_valid <= 0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d loads and %0d reads, %0d frames carved with %0d seams",
			loads_sent, reads_sent, frames_carved, seams_carved);
		$display("%0d pixels checked, %0d errors", pixels_checked, errors);
		if (errors == 0 && expected_pixels.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
